// ===== rtl/sit_pkg.sv =====
// Shared constants, codes and the control and overlap-flag structs of the sorted interval table.
package sit_pkg;

  localparam int DEPTH_DEF         = 64;
  localparam int POSITION_BITS_DEF = 11;

  localparam int TAG_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERLAP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic commit;
    logic rd;
  } sit_ctl_t;

  // Overlap flags against the predecessor and the successor of a new region.
  typedef struct packed {
    logic pred;
    logic succ;
  } sit_hit_t;

endpackage

// ===== rtl/sit_cell.sv =====
// One table slot: holds a region, compares it with the new one and shifts up on insert.
module sit_cell #(
  parameter int POSITION_BITS = sit_pkg::POSITION_BITS_DEF,
  parameter int CELL_IDX      = 0
) (
  input  logic                       clk,
  input  logic                       valid,
  input  logic                       prev_lt,
  input  logic                       next_lt,
  input  logic                       pred_any,
  input  logic [POSITION_BITS-1:0]   prev_start,
  input  logic [POSITION_BITS:0]     prev_length,
  input  logic [sit_pkg::TAG_W-1:0]  prev_tag,
  input  logic [POSITION_BITS-1:0]   new_start,
  input  logic [POSITION_BITS:0]     new_length,
  input  logic [sit_pkg::TAG_W-1:0]  new_tag,
  input  logic [sit_pkg::POS_W-1:0]  pos,
  input  sit_pkg::sit_ctl_t          ctl,
  output logic                       lt,
  output sit_pkg::sit_hit_t          hit,
  output logic [POSITION_BITS-1:0]   start,
  output logic [POSITION_BITS:0]     length,
  output logic [sit_pkg::TAG_W-1:0]  tag,
  output logic [POSITION_BITS-1:0]   sel_start,
  output logic [POSITION_BITS:0]     sel_length,
  output logic [sit_pkg::TAG_W-1:0]  sel_tag
);
  import sit_pkg::*;

  localparam int END_W = POSITION_BITS + 2;

  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS:0]   length_r;
  logic [TAG_W-1:0]         tag_r;
  logic                     at_here;
  logic                     is_pred;
  logic                     is_succ;
  logic                     pick;
  logic [END_W-1:0]         own_end;
  logic [END_W-1:0]         new_end;

  always_comb begin
    lt      = valid && (start_r < new_start);
    // First slot not below the new start is where the new region lands.
    at_here = prev_lt && !lt;
    is_pred = lt && !next_lt;
    is_succ = valid && at_here;
    own_end = END_W'(start_r) + END_W'(length_r) - END_W'(1);
    new_end = END_W'(new_start) + END_W'(new_length) - END_W'(1);
    hit.pred = is_pred && (END_W'(new_start) <= own_end);
    hit.succ = is_succ && (END_W'(start_r) <= new_end);
  end

  always_comb begin
    if (ctl.rd) begin
      pick = (CELL_IDX == int'(pos));
    end else begin
      pick = pred_any ? hit.pred : hit.succ;
    end
    sel_start  = pick ? start_r  : '0;
    sel_length = pick ? length_r : '0;
    sel_tag    = pick ? tag_r    : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (at_here) begin
        start_r  <= new_start;
        length_r <= new_length;
        tag_r    <= new_tag;
      end else if (!lt) begin
        // Make room: take the neighbor below.
        start_r  <= prev_start;
        length_r <= prev_length;
        tag_r    <= prev_tag;
      end
    end
  end

  assign start  = start_r;
  assign length = length_r;
  assign tag    = tag_r;

endmodule

// ===== rtl/sit_chain.sv =====
// Row of table cells with the flag and selection reduction across the row.
module sit_chain #(
  parameter int TABLE_DEPTH   = sit_pkg::DEPTH_DEF,
  parameter int POSITION_BITS = sit_pkg::POSITION_BITS_DEF,
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic [CNT_W-1:0]           filled,
  input  logic [POSITION_BITS-1:0]   new_start,
  input  logic [POSITION_BITS:0]     new_length,
  input  logic [sit_pkg::TAG_W-1:0]  new_tag,
  input  logic [sit_pkg::POS_W-1:0]  pos,
  input  sit_pkg::sit_ctl_t          ctl,
  output sit_pkg::sit_hit_t          hit,
  output logic [POSITION_BITS-1:0]   found_start,
  output logic [POSITION_BITS:0]     found_length,
  output logic [sit_pkg::TAG_W-1:0]  found_tag
);
  import sit_pkg::*;

  logic                     valid_v [TABLE_DEPTH];
  logic                     lt_v    [TABLE_DEPTH];
  sit_hit_t                 hit_v   [TABLE_DEPTH];
  logic [POSITION_BITS-1:0] start_v [TABLE_DEPTH];
  logic [POSITION_BITS:0]   len_v   [TABLE_DEPTH];
  logic [TAG_W-1:0]         tag_v   [TABLE_DEPTH];
  logic [POSITION_BITS-1:0] sstart_v[TABLE_DEPTH];
  logic [POSITION_BITS:0]   slen_v  [TABLE_DEPTH];
  logic [TAG_W-1:0]         stag_v  [TABLE_DEPTH];
  logic                     pred_any;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                     prev_lt;
    logic                     next_lt;
    logic [POSITION_BITS-1:0] prev_start;
    logic [POSITION_BITS:0]   prev_length;
    logic [TAG_W-1:0]         prev_tag;

    assign valid_v[i] = (i < int'(filled));

    if (i == 0) begin : g_first
      assign prev_lt     = 1'b1;
      assign prev_start  = '0;
      assign prev_length = '0;
      assign prev_tag    = '0;
    end else begin : g_mid
      assign prev_lt     = lt_v[i-1];
      assign prev_start  = start_v[i-1];
      assign prev_length = len_v[i-1];
      assign prev_tag    = tag_v[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_lt = 1'b0;
    end else begin : g_inner
      assign next_lt = lt_v[i+1];
    end

    sit_cell #(
      .POSITION_BITS(POSITION_BITS),
      .CELL_IDX     (i)
    ) u_cell (
      .clk        (clk),
      .valid      (valid_v[i]),
      .prev_lt    (prev_lt),
      .next_lt    (next_lt),
      .pred_any   (pred_any),
      .prev_start (prev_start),
      .prev_length(prev_length),
      .prev_tag   (prev_tag),
      .new_start  (new_start),
      .new_length (new_length),
      .new_tag    (new_tag),
      .pos        (pos),
      .ctl        (ctl),
      .lt         (lt_v[i]),
      .hit        (hit_v[i]),
      .start      (start_v[i]),
      .length     (len_v[i]),
      .tag        (tag_v[i]),
      .sel_start  (sstart_v[i]),
      .sel_length (slen_v[i]),
      .sel_tag    (stag_v[i])
    );
  end

  always_comb begin
    hit = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit.pred = hit.pred | hit_v[i].pred;
      hit.succ = hit.succ | hit_v[i].succ;
    end
    pred_any = hit.pred;
  end

  // At most one cell selects, so an OR merges the row.
  always_comb begin
    found_start  = '0;
    found_length = '0;
    found_tag    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found_start  = found_start  | sstart_v[i];
      found_length = found_length | slen_v[i];
      found_tag    = found_tag    | stag_v[i];
    end
  end

endmodule

// ===== rtl/sorted_interval_table_top.sv =====
// Sorted interval table: an item is first captured, then in the evaluation state every
// cell compares its region with the new one in parallel and, on a clean insert, the
// cells at and above the insert point shift up by one; the result is registered when
// evaluation ends. in_stall is high during evaluation, which also holds while a previous
// result is still waiting on out_stall, so the block takes no new item before it is done
// with the last one. The table needs no clearing after reset.
module sorted_interval_table_top #(
  parameter int TABLE_DEPTH   = sit_pkg::DEPTH_DEF,
  parameter int POSITION_BITS = sit_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [POSITION_BITS-1:0]       in_region_start,
  input  logic [POSITION_BITS:0]         in_region_length,
  input  logic [sit_pkg::TAG_W-1:0]      in_region_tag,
  input  logic [sit_pkg::POS_W-1:0]      in_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sit_pkg::STATUS_W-1:0]   out_status,
  output logic [POSITION_BITS-1:0]       out_found_start,
  output logic [POSITION_BITS:0]         out_found_length,
  output logic [sit_pkg::TAG_W-1:0]      out_found_tag,
  output logic [sit_pkg::COUNT_W-1:0]    out_entry_count
);
  import sit_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic                     state_r, state_nxt;
  logic [CNT_W-1:0]         filled_r, filled_nxt;
  logic                     cmd_r;
  logic [POSITION_BITS-1:0] start_r;
  logic [POSITION_BITS:0]   length_r;
  logic [TAG_W-1:0]         tag_r;
  logic [POS_W-1:0]         pos_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [POSITION_BITS-1:0] fstart_r;
  logic [POSITION_BITS:0]   flength_r;
  logic [TAG_W-1:0]         ftag_r;
  logic [COUNT_W-1:0]       count_r;

  logic                     accept;
  logic                     go;
  logic                     is_rd;
  logic                     rd_ok;
  logic                     len_zero;
  logic                     full;
  logic                     conf;
  logic                     show;
  sit_ctl_t                 ctl;
  sit_hit_t                 hit;
  logic [POSITION_BITS-1:0] ch_start;
  logic [POSITION_BITS:0]   ch_length;
  logic [TAG_W-1:0]         ch_tag;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // Finish only when the output register is free or being emptied.
  assign go       = (state_r == S_EVAL) && (!out_valid_r || !out_stall);

  always_comb begin
    is_rd    = (cmd_r == CMD_READ);
    rd_ok    = int'(pos_r) < int'(filled_r);
    len_zero = (length_r == '0);
    full     = (filled_r == CNT_W'(TABLE_DEPTH));
    conf     = hit.pred || hit.succ;
    if (is_rd) begin
      status_nxt = rd_ok ? ST_OK : ST_EMPTY;
      show       = rd_ok;
    end else if (len_zero) begin
      status_nxt = ST_BAD_LENGTH;
      show       = 1'b0;
    end else if (full) begin
      status_nxt = ST_FULL;
      show       = 1'b0;
    end else if (conf) begin
      status_nxt = ST_OVERLAP;
      show       = 1'b1;
    end else begin
      status_nxt = ST_OK;
      show       = 1'b0;
    end
    ctl.rd     = is_rd;
    ctl.commit = go && (cmd_r == CMD_INSERT) && !len_zero && !full && !conf;
    filled_nxt = filled_r + CNT_W'(ctl.commit);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  sit_chain #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_chain (
    .clk         (clk),
    .filled      (filled_r),
    .new_start   (start_r),
    .new_length  (length_r),
    .new_tag     (tag_r),
    .pos         (pos_r),
    .ctl         (ctl),
    .hit         (hit),
    .found_start (ch_start),
    .found_length(ch_length),
    .found_tag   (ch_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      start_r  <= in_region_start;
      length_r <= in_region_length;
      tag_r    <= in_region_tag;
      pos_r    <= in_position;
    end
    if (go) begin
      status_r  <= status_nxt;
      fstart_r  <= show ? ch_start  : '0;
      flength_r <= show ? ch_length : '0;
      ftag_r    <= show ? ch_tag    : '0;
      count_r   <= COUNT_W'(filled_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_found_start  = fstart_r;
  assign out_found_length = flength_r;
  assign out_found_tag    = ftag_r;
  assign out_entry_count  = count_r;

endmodule

// ===== rtl/sit_checker.sv =====
// Port-level checks of the sorted interval table, bound to the top level.
module sit_checker #(
  parameter int POSITION_BITS = sit_pkg::POSITION_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [sit_pkg::STATUS_W-1:0]   out_status,
  input logic [POSITION_BITS-1:0]       out_found_start,
  input logic [POSITION_BITS:0]         out_found_length,
  input logic [sit_pkg::TAG_W-1:0]      out_found_tag,
  input logic [sit_pkg::COUNT_W-1:0]    out_entry_count
);
  import sit_pkg::*;

  // An accepted item blocks the input while it is evaluated.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_entry_count) && $stable(out_found_tag))
    else $error("stalled result changed");

  a_no_found_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD_LENGTH || out_status == ST_FULL
      || out_status == ST_EMPTY)
      |-> out_found_start == '0 && out_found_length == '0 && out_found_tag == '0)
    else $error("found fields set on a result that reports none");

  // Stored regions never have zero length.
  a_conflict_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERLAP |-> out_found_length != '0)
    else $error("overlap reported against an empty region");

endmodule

bind sorted_interval_table_top sit_checker #(.POSITION_BITS(POSITION_BITS)) u_sit_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sorted interval table: inserts, overlap rejects and reads.
module tb_top;
  import sit_pkg::*;

  localparam int PB        = POSITION_BITS_DEF;
  localparam int DEPTH     = DEPTH_DEF;
  localparam int MAX_START = (1 << PB) - 1;
  localparam int MAX_LEN   = (1 << (PB + 1)) - 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PB-1:0]       fstart;
    logic [PB:0]         flen;
    logic [TAG_W-1:0]    ftag;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  class interval_scoreboard;
    logic [PB-1:0]    start_q[DEPTH];
    logic [PB:0]      len_q[DEPTH];
    logic [TAG_W-1:0] tag_q[DEPTH];
    int unsigned      filled;
    int unsigned      errors;
    table_result_t    expected_q[$];

    // Regions meet when each starts no later than the other's last bit; no wrap.
    function bit regions_meet(int s0, int l0, int s1, int l1);
      return (s1 <= s0 + l0 - 1) && (s0 <= s1 + l1 - 1);
    endfunction

    function table_result_t show_entry(int unsigned idx, logic [STATUS_W-1:0] status);
      table_result_t r;
      r        = '0;
      r.status = status;
      r.fstart = start_q[idx];
      r.flen   = len_q[idx];
      r.ftag   = tag_q[idx];
      return r;
    endfunction

    function void note_input(logic cmd, logic [PB-1:0] start, logic [PB:0] len,
                             logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
      table_result_t r;
      int unsigned   at;
      r = '0;
      if (cmd == CMD_READ) begin
        if (pos < filled) r = show_entry(pos, ST_OK);
        else r.status = ST_EMPTY;
      end else if (len == 0) begin
        r.status = ST_BAD_LENGTH;
      end else if (filled >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new region sorts ahead of entries with an equal start
        at = 0;
        while (at < filled && start_q[at] < start) at++;
        if (at > 0 && regions_meet(start_q[at-1], len_q[at-1], start, len)) begin
          r = show_entry(at - 1, ST_OVERLAP);
        end else if (at < filled && regions_meet(start, len, start_q[at], len_q[at])) begin
          r = show_entry(at, ST_OVERLAP);
        end else begin
          for (int k = filled; k > at; k--) begin
            start_q[k] = start_q[k-1];
            len_q[k]   = len_q[k-1];
            tag_q[k]   = tag_q[k-1];
          end
          start_q[at] = start;
          len_q[at]   = len;
          tag_q[at]   = tag;
          filled++;
          r.status = ST_OK;
        end
      end
      r.count = COUNT_W'(filled);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100)
        $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    task check_result(table_result_t got);
      table_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, '0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.fstart !== want.fstart) report_mismatch("found_start", got.fstart, want.fstart);
      if (got.flen !== want.flen)     report_mismatch("found_length", got.flen, want.flen);
      if (got.ftag !== want.ftag)     report_mismatch("found_tag", got.ftag, want.ftag);
      if (got.count !== want.count)   report_mismatch("entry_count", got.count, want.count);
    endtask

    // Start a region close to either end of a stored one: mostly overlaps, some abut.
    function int near_start(int len);
      int i;
      int s;
      if (filled == 0) return int'($urandom_range(MAX_START));
      i = int'($urandom_range(filled - 1));
      if ($urandom_range(1))
        s = int'(start_q[i]) + int'(len_q[i]) + int'($urandom_range(4)) - 3;
      else
        s = int'(start_q[i]) - len + int'($urandom_range(4)) - 1;
      if (s < 0) s = 0;
      if (s > MAX_START) s = MAX_START;
      return s;
    endfunction

    // First bit position covered by no entry, or -1.
    function int free_start();
      bit taken;
      for (int b = 0; b <= MAX_START; b++) begin
        taken = 1'b0;
        for (int i = 0; i < filled; i++)
          if (b >= start_q[i] && b <= int'(start_q[i]) + int'(len_q[i]) - 1) taken = 1'b1;
        if (!taken) return b;
      end
      return -1;
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_cmd;
  logic [PB-1:0]       in_region_start;
  logic [PB:0]         in_region_length;
  logic [TAG_W-1:0]    in_region_tag;
  logic [POS_W-1:0]    in_position;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [PB-1:0]       out_found_start;
  logic [PB:0]         out_found_length;
  logic [TAG_W-1:0]    out_found_tag;
  logic [COUNT_W-1:0]  out_entry_count;

  interval_scoreboard sb = new;
  bit quiet;
  bit hold_req;

  sorted_interval_table_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_region_start  (in_region_start),
    .in_region_length (in_region_length),
    .in_region_tag    (in_region_tag),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found_start  (out_found_start),
    .out_found_length (out_found_length),
    .out_found_tag    (out_found_tag),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(logic cmd, logic [PB-1:0] start, logic [PB:0] len,
                           logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
    int unsigned gap;
    if (!quiet && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_region_start  <= start;
    in_region_length <= len;
    in_region_tag    <= tag;
    in_position      <= pos;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, start, len, tag, pos);
  endtask

  task automatic insert_region(int start, int len, logic [TAG_W-1:0] tag);
    send_item(CMD_INSERT, PB'(start), (PB+1)'(len), tag, POS_W'($urandom()));
  endtask

  task automatic read_entry(int pos);
    send_item(CMD_READ, PB'($urandom()), (PB+1)'($urandom()), $urandom(), POS_W'(pos));
  endtask

  function automatic logic [PB:0] rand_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return (PB+1)'($urandom_range(1, 16));
    if (r < 95) return (PB+1)'($urandom_range(17, 128));
    return (PB+1)'($urandom_range(129, MAX_LEN));
  endfunction

  task automatic random_item();
    int unsigned      roll;
    logic [PB:0]      len;
    logic [POS_W-1:0] pos;
    roll = $urandom_range(99);
    len  = rand_length();
    pos  = POS_W'($urandom());
    if (roll < 40) begin
      // favor positions that hold an entry
      if (sb.filled > 0 && $urandom_range(3) != 0) pos = POS_W'($urandom_range(sb.filled - 1));
      send_item(CMD_READ, PB'($urandom()), len, $urandom(), pos);
    end else if (roll < 45) begin
      send_item(CMD_INSERT, PB'($urandom()), '0, $urandom(), pos);
    end else if (roll < 80) begin
      send_item(CMD_INSERT, PB'(sb.near_start(len)), len, $urandom(), pos);
    end else if (roll < 85) begin
      send_item(CMD_INSERT, $urandom_range(1) ? PB'(MAX_START) : PB'($urandom()),
                $urandom_range(1) ? (PB+1)'(MAX_LEN) : (PB+1)'(1 << PB), $urandom(), pos);
    end else begin
      send_item(CMD_INSERT, PB'($urandom()), len, $urandom(), pos);
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result({out_status, out_found_start, out_found_length, out_found_tag,
                         out_entry_count});
      if (hold_req) begin
        hold_left = 60;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 7);
      end
    end
  end

  initial begin : stimulus
    int unsigned waited;
    int          b;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_cmd           <= CMD_INSERT;
    in_region_start  <= '0;
    in_region_length <= '0;
    in_region_tag    <= '0;
    in_position      <= '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, zero length, extremes, equal starts, both neighbors in conflict
    read_entry(0);
    read_entry(63);
    insert_region(5, 0, 32'h1234_5678);
    insert_region(MAX_START, MAX_LEN, 32'hFFFF_FFFF);
    insert_region(0, 1, 32'h0);
    insert_region(0, 1, 32'hA5A5_A5A5);
    insert_region(MAX_START, 1, 32'h5A5A_5A5A);
    insert_region(2040, 8, $urandom());
    insert_region(2039, 8, $urandom());
    insert_region(1, 5, $urandom());
    insert_region(3, 1, $urandom());
    insert_region(1000, 100, $urandom());
    insert_region(950, 51, $urandom());
    insert_region(1050, 100, $urandom());
    insert_region(4, 1000, $urandom());
    insert_region(1100, 1 << PB, $urandom());
    insert_region(6, 1, $urandom());
    for (int p = 0; p <= 6; p++) read_entry(p);
    read_entry(63);

    for (int i = 0; i < 1100; i++) begin
      quiet = (i >= 400 && i < 600);
      // back up the result side so the block stalls its input
      if (i == 150 || i == 900) hold_req = 1'b1;
      random_item();
    end
    quiet = 1'b0;

    // top up to a full table with one-bit regions in free space
    b = sb.free_start();
    while (sb.filled < DEPTH && b >= 0) begin
      insert_region(b, 1, $urandom());
      b = sb.free_start();
    end
    for (int i = 0; i < 120; i++) random_item();
    in_valid <= 1'b0;

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
